### design/fbsc_pkg.sv
package fbsc_pkg;

   // Parser phases, one-hot.
   typedef enum logic [5:0] {
      PH_HEADER = 6'b000001,
      PH_SKIP   = 6'b000010,
      PH_TEXT   = 6'b000100,
      PH_HEX    = 6'b001000,
      PH_DONE   = 6'b010000,
      PH_HALT   = 6'b100000
   } phase_type;

   // Event codes carried by a result without a character.
   localparam logic [1:0] EV_NONE    = 2'd0;
   localparam logic [1:0] EV_END     = 2'd1;
   localparam logic [1:0] EV_UNIMPL  = 2'd2;
   localparam logic [1:0] EV_UNKNOWN = 2'd3;

   // Block types found in the fifth header byte.
   localparam logic [7:0] KIND_SKIP     = 8'd0;
   localparam logic [7:0] KIND_TEXT     = 8'd1;
   localparam logic [7:0] KIND_HEX      = 8'd2;
   localparam logic [7:0] KIND_UNIMPL_A = 8'd3;
   localparam logic [7:0] KIND_UNIMPL_B = 8'd4;
   localparam logic [7:0] KIND_END      = 8'd5;

   // Header layout: four size bytes, then the type byte, then one spare byte.
   localparam logic [2:0] HDR_KIND_IDX = 3'd4;

   // Amounts subtracted from the block size to get the body length.
   localparam logic [32:0] SKIP_OVERHEAD = 33'd6;
   localparam logic [32:0] BODY_OVERHEAD = 33'd2;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   // Register indexes and reset values.
   localparam logic REG_IGNORE_ERRORS = 1'b0;
   localparam logic REG_LINE_BYTES    = 1'b1;
   localparam logic [7:0] LINE_BYTES_RESET = 8'd40;
   localparam logic [8:0] LINE_BYTES_MAX   = 9'd256;

   typedef struct packed {
      logic       ignore_errors;
      logic [7:0] line_bytes;
   } cfg_type;

   // Up to three results caused by one input item.
   typedef struct packed {
      logic [1:0]      count;
      logic [1:0]      ev;
      logic [2:0][7:0] ch;
   } group_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] wide;
      wide = {4'd0, v};
      return (v < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
   endfunction

endpackage

### design/fbsc_parser.sv
module fbsc_parser
   import fbsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       new_file,
   input  cfg_type    cfg,
   output group_type  grp
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  hidx_ff, hidx_in;
   logic [31:0] size_ff, size_in;
   logic [7:0]  kind_ff, kind_in;
   logic [31:0] left_ff, left_in;
   logic [7:0]  lcount_ff, lcount_in;

   phase_type   eff_phase;
   logic [2:0]  eff_hidx;
   logic [32:0] overhead;
   logic [32:0] body_len;
   logic        body_nonempty;
   logic [31:0] left_dec;
   logic [8:0]  line_next;
   logic [8:0]  line_limit;
   phase_type   body_phase;
   logic [1:0]  ev;

   always_comb begin
      // A new file restarts the header from any phase.
      eff_phase = new_file ? PH_HEADER : phase_ff;
      eff_hidx  = new_file ? 3'd0 : hidx_ff;

      overhead      = (kind_ff == KIND_SKIP) ? SKIP_OVERHEAD : BODY_OVERHEAD;
      body_len      = {size_ff[31], size_ff} - overhead;
      body_nonempty = !body_len[32] && (body_len[31:0] != 32'd0);
      left_dec      = left_ff - 32'd1;
      line_next     = {1'b0, lcount_ff} + 9'd1;
      line_limit    = (cfg.line_bytes == 8'd0) ? LINE_BYTES_MAX : {1'b0, cfg.line_bytes};

      phase_in  = eff_phase;
      hidx_in   = eff_hidx;
      size_in   = size_ff;
      kind_in   = kind_ff;
      left_in   = left_ff;
      lcount_in = lcount_ff;
      grp       = '0;
      body_phase = PH_HEADER;
      ev        = EV_NONE;

      case (eff_phase)
         PH_HEADER: begin
            if (eff_hidx < HDR_KIND_IDX) begin
               size_in = (eff_hidx == 3'd0) ? {24'd0, data_byte} : {size_ff[23:0], data_byte};
               hidx_in = eff_hidx + 3'd1;
            end else if (eff_hidx == HDR_KIND_IDX) begin
               kind_in = data_byte;
               hidx_in = eff_hidx + 3'd1;
            end else begin
               hidx_in = 3'd0;
               case (kind_ff)
                  KIND_SKIP:     body_phase = PH_SKIP;
                  KIND_TEXT:     body_phase = PH_TEXT;
                  KIND_HEX:      body_phase = PH_HEX;
                  KIND_END:      ev = EV_END;
                  KIND_UNIMPL_A: ev = EV_UNIMPL;
                  KIND_UNIMPL_B: ev = EV_UNIMPL;
                  default:       ev = EV_UNKNOWN;
               endcase
               if (ev == EV_NONE) begin
                  if (body_nonempty) begin
                     left_in   = body_len[31:0];
                     lcount_in = 8'd0;
                     phase_in  = body_phase;
                  end else begin
                     left_in  = 32'd0;
                     phase_in = PH_HEADER;
                  end
               end else if (ev == EV_END) begin
                  phase_in = PH_DONE;
               end else begin
                  phase_in = cfg.ignore_errors ? PH_HEADER : PH_HALT;
               end
               if (ev != EV_NONE) begin
                  grp.count = 2'd1;
                  grp.ev    = ev;
               end
            end
         end
         PH_SKIP, PH_TEXT, PH_HEX: begin
            left_in = left_dec;
            if (left_dec == 32'd0) begin
               phase_in = PH_HEADER;
            end
            if (eff_phase == PH_TEXT) begin
               grp.count = 2'd1;
               grp.ch[0] = (data_byte == CHAR_CR) ? CHAR_LF : data_byte;
            end else if (eff_phase == PH_HEX) begin
               grp.ch[0] = hex_digit(data_byte[7:4]);
               grp.ch[1] = hex_digit(data_byte[3:0]);
               if (line_next >= line_limit) begin
                  grp.count = 2'd3;
                  grp.ch[2] = CHAR_LF;
                  lcount_in = 8'd0;
               end else begin
                  grp.count = 2'd2;
                  lcount_in = line_next[7:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         hidx_ff   <= 3'd0;
         size_ff   <= 32'd0;
         kind_ff   <= 8'd0;
         left_ff   <= 32'd0;
         lcount_ff <= 8'd0;
      end else if (step) begin
         phase_ff  <= phase_in;
         hidx_ff   <= hidx_in;
         size_ff   <= size_in;
         kind_ff   <= kind_in;
         left_ff   <= left_in;
         lcount_ff <= lcount_in;
      end
   end

endmodule

### design/font_block_stream_converter.sv
// Font block stream converter. Input items are the raw bytes of a font file,
// one per item, with req_tuser marking the first byte of a new file. Each
// block of the file opens with a six-byte header (32-bit big-endian signed
// size, type byte, spare byte); skip blocks are dropped, text blocks are
// copied with CR turned into LF, hex blocks come out as two uppercase hex
// digits per byte with a newline after every line_bytes bytes, and the end,
// unimplemented and unknown types each give one event result. Every item is
// decoded in the cycle it is accepted, and its results (zero to three) are
// held in one result register that drives a single output item per cycle
// while rsp_tready is high; rsp_tlast marks the final result of an input
// item. A hex byte's two or three results therefore leave one after another
// on the single-width result port. The next input item is taken in the same
// cycle that the last pending result leaves. Configuration is to be written
// over the APB-style port only while the block is idle; the block itself
// does not enforce this.
module font_block_stream_converter
   import fbsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] new_file

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_char
   output logic [2:0]  rsp_tuser,   // [0] char_valid, [2:1] event_res
   output logic        rsp_tlast,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type    cfg_ff;
   group_type  parsed;
   group_type  grp_ff;
   logic       grp_valid_ff;
   logic [1:0] pos_ff;

   logic       csr_write;
   logic       req_accept;
   logic       out_take;
   logic       last_take;

   // Configuration registers. Only paddr[2] selects the register.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ignore_errors <= 1'b0;
         cfg_ff.line_bytes    <= LINE_BYTES_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            REG_IGNORE_ERRORS: cfg_ff.ignore_errors <= csr_pwdata[0];
            REG_LINE_BYTES:    cfg_ff.line_bytes    <= csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_IGNORE_ERRORS: csr_prdata = {31'd0, cfg_ff.ignore_errors};
         REG_LINE_BYTES:    csr_prdata = {24'd0, cfg_ff.line_bytes};
         default:           csr_prdata = 32'd0;
      endcase
   end

   // Handshakes. A new item may enter when the result register is empty or
   // its final result leaves in this cycle.
   assign out_take   = rsp_tvalid && rsp_tready;
   assign last_take  = out_take && (pos_ff == (grp_ff.count - 2'd1));
   assign req_tready = !grp_valid_ff || last_take;
   assign req_accept = req_tvalid && req_tready;

   fbsc_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (req_accept),
      .data_byte (req_tdata),
      .new_file  (req_tuser),
      .cfg       (cfg_ff),
      .grp       (parsed)
   );

   // Result register and the position of the result being presented.
   always_ff @(posedge clock) begin
      if (reset) begin
         grp_valid_ff <= 1'b0;
         pos_ff       <= 2'd0;
      end else if (req_accept && (parsed.count != 2'd0)) begin
         grp_valid_ff <= 1'b1;
         pos_ff       <= 2'd0;
      end else if (last_take) begin
         grp_valid_ff <= 1'b0;
         pos_ff       <= 2'd0;
      end else if (out_take) begin
         pos_ff <= pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && (parsed.count != 2'd0)) begin
         grp_ff <= parsed;
      end
   end

   assign rsp_tvalid = grp_valid_ff;
   assign rsp_tdata  = (grp_ff.ev == EV_NONE) ? grp_ff.ch[pos_ff] : 8'd0;
   assign rsp_tuser  = {grp_ff.ev, grp_ff.ev == EV_NONE};
   assign rsp_tlast  = pos_ff == (grp_ff.count - 2'd1);

   // The presented position always lies inside the stored group.
   a_pos_in_group: assert property (@(posedge clock) disable iff (reset)
      grp_valid_ff |-> (pos_ff < grp_ff.count))
      else $error("result position beyond group size");

   // An event is always a group of one result.
   a_event_single: assert property (@(posedge clock) disable iff (reset)
      (grp_valid_ff && (grp_ff.ev != EV_NONE)) |-> (grp_ff.count == 2'd1))
      else $error("event result group holds more than one result");

   // A taken result that is not the last moves to the next one.
   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      (out_take && !last_take) |=> (grp_valid_ff && (pos_ff == $past(pos_ff) + 2'd1)))
      else $error("result position did not advance");

   // With the last result gone and nothing new entering, the output goes idle.
   a_drain_idle: assert property (@(posedge clock) disable iff (reset)
      (last_take && !req_accept) |=> !rsp_tvalid)
      else $error("stale result presented after group drained");

endmodule

### sim/tb_font_block_stream_converter.sv
module tb_font_block_stream_converter;
   timeunit 1ns;
   timeprecision 1ps;

   import fbsc_pkg::*;

   // The run ends here if the block stops moving.
   localparam int CYCLE_LIMIT   = 200000;
   // After this many bytes have gone in, the receiver refuses results for a
   // long stretch so that the result register fills and the input stalls.
   localparam int HOLD_AT       = 100;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTINGS      = 5;
   localparam int BYTES_PER_SET = 54;
   localparam int DRAIN_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;

   // How the receiver paces rsp_tready.
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PATTERN
   } ready_mode_type;

   // One byte of a font file on its way in. A row of the directed table may
   // carry its results typed in by hand (up to three characters, lowest byte
   // first, or one event); otherwise the parser model supplies them.
   typedef struct packed {
      logic [7:0]  data;
      logic        nf;
      logic        typed;
      logic [1:0]  n_typed;
      logic [1:0]  ev_typed;
      logic [23:0] ch_typed;
   } font_byte_type;

   // One output item: a character or an event, and whether it closes the
   // results of its input byte.
   typedef struct packed {
      logic [7:0] ch;
      logic       valid;
      logic [1:0] ev;
      logic       last;
   } text_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] data_byte
   logic        req_tuser = 1'b0;   // [0] new_file

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // [7:0] out_char
   logic [2:0]  rsp_tuser;          // [0] char_valid, [2:1] event_res
   logic        rsp_tlast;

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   font_block_stream_converter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Parser model: its own copy of the registers and of the parser state.
   // ------------------------------------------------------------------------
   logic        ign_err;
   logic [7:0]  line_len;
   phase_type   parse_phase;
   logic [2:0]  hdr_index;
   logic [31:0] blk_size;
   logic [7:0]  blk_kind;
   logic [31:0] body_left;
   logic [7:0]  line_pos;

   // Results of the byte most recently run through the model.
   text_out_type step_out [3];
   int           step_count;

   font_byte_type byte_queue [$];       // bytes waiting to be offered
   text_out_type  converted_chars [$];  // results owed by the block, oldest first
   font_byte_type offered_byte;

   int          bytes_taken = 0;
   int          bytes_queued = 0;
   int          chars_checked = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   bit          restart_due = 1'b0;

   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      string digits;
      digits = "0123456789ABCDEF";
      return digits[nibble];
   endfunction

   function automatic void note_result(input logic [7:0] ch, input logic valid,
                                       input logic [1:0] ev);
      step_out[step_count] = {ch, valid, ev, 1'b0};
      step_count++;
   endfunction

   // A body whose worked-out length is zero or negative is empty, and the next
   // byte belongs to a header again.
   function automatic void open_body(input longint count, input phase_type nxt);
      if (count > 0) begin
         body_left   = count[31:0];
         line_pos    = 8'd0;
         parse_phase = nxt;
      end else begin
         body_left   = 32'd0;
         parse_phase = PH_HEADER;
      end
   endfunction

   function automatic void consume_body();
      body_left--;
      if (body_left == 32'd0) parse_phase = PH_HEADER;
   endfunction

   function automatic void convert_font_byte(input logic [7:0] b, input logic nf);
      longint     signed_size;
      logic [1:0] ev;
      int         line_limit;
      step_count = 0;
      if (nf) begin
         parse_phase = PH_HEADER;
         hdr_index   = 3'd0;
      end
      case (parse_phase)
         PH_HEADER: begin
            if (hdr_index < HDR_KIND_IDX) begin
               blk_size  = (hdr_index == 3'd0) ? {24'd0, b} : {blk_size[23:0], b};
               hdr_index = hdr_index + 3'd1;
            end else if (hdr_index == HDR_KIND_IDX) begin
               blk_kind  = b;
               hdr_index = hdr_index + 3'd1;
            end else begin
               // Sixth byte: the header is complete and the block starts.
               hdr_index   = 3'd0;
               ev          = EV_NONE;
               signed_size = longint'($signed(blk_size));
               case (blk_kind)
                  KIND_SKIP: open_body(signed_size - longint'(SKIP_OVERHEAD), PH_SKIP);
                  KIND_TEXT: open_body(signed_size - longint'(BODY_OVERHEAD), PH_TEXT);
                  KIND_HEX:  open_body(signed_size - longint'(BODY_OVERHEAD), PH_HEX);
                  KIND_END: begin
                     ev          = EV_END;
                     parse_phase = PH_DONE;
                  end
                  KIND_UNIMPL_A, KIND_UNIMPL_B: ev = EV_UNIMPL;
                  default: ev = EV_UNKNOWN;
               endcase
               if (ev == EV_UNIMPL || ev == EV_UNKNOWN)
                  parse_phase = ign_err ? PH_HEADER : PH_HALT;
               if (ev != EV_NONE) note_result(8'd0, 1'b0, ev);
            end
         end
         PH_SKIP: consume_body();
         PH_TEXT: begin
            note_result((b == CHAR_CR) ? CHAR_LF : b, 1'b1, EV_NONE);
            consume_body();
         end
         PH_HEX: begin
            line_limit = (line_len == 8'd0) ? 256 : int'(line_len);
            note_result(hex_char(b[7:4]), 1'b1, EV_NONE);
            note_result(hex_char(b[3:0]), 1'b1, EV_NONE);
            if (int'(line_pos) + 1 >= line_limit) begin
               note_result(CHAR_LF, 1'b1, EV_NONE);
               line_pos = 8'd0;
            end else begin
               line_pos = line_pos + 8'd1;
            end
            consume_body();
         end
         default: ;  // after the end of the font or a halt, bytes are dropped
      endcase
      if (step_count > 0) step_out[step_count - 1].last = 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Sender. Bytes leave byte_queue in bursts of random length separated by
   // random gaps; a gap of zero joins two bursts into a stretch with no idle
   // cycle. Each accepted byte goes through the parser model at the edge of
   // its handshake, which keeps the model in step with the block.
   // ------------------------------------------------------------------------
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid  <= 1'b0;
         req_tdata   <= 8'd0;
         req_tuser   <= 1'b0;
         ign_err     = 1'b0;
         line_len    = LINE_BYTES_RESET;
         parse_phase = PH_HEADER;
         hdr_index   = 3'd0;
         blk_size    = 32'd0;
         blk_kind    = 8'd0;
         body_left   = 32'd0;
         line_pos    = 8'd0;
         burst_left  = 1;
         gap_left    = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            convert_font_byte(offered_byte.data, offered_byte.nf);
            // A hand-typed row still runs through the model so that the parser
            // state stays right, but its own results are what the block owes.
            if (offered_byte.typed) begin
               for (int i = 0; i < int'(offered_byte.n_typed); i++)
                  converted_chars.push_back({offered_byte.ch_typed[8*i +: 8],
                                             offered_byte.ev_typed == EV_NONE,
                                             offered_byte.ev_typed,
                                             i == int'(offered_byte.n_typed) - 1});
            end else begin
               for (int i = 0; i < step_count; i++) converted_chars.push_back(step_out[i]);
            end
            bytes_taken <= bytes_taken + 1;
         end
         // A new byte may only be put up when the current one is gone.
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (byte_queue.size() != 0) begin
               offered_byte = byte_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= offered_byte.data;
               req_tuser  <= offered_byte.nf;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver. It switches between pacing modes at random intervals, and once
   // in the run it holds rsp_tready low while the sender keeps offering bytes.
   // ------------------------------------------------------------------------
   ready_mode_type ready_mode = READY_ALWAYS;
   int             mode_left = 0;
   int             hold_left = 0;
   bit             hold_done = 1'b0;
   logic [7:0]     ready_pattern = 8'hFF;
   logic [2:0]     pattern_pos = 3'd0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (!hold_done && bytes_taken >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               ready_mode    = ready_mode_type'($urandom_range(0, 3));
               ready_pattern = 8'($urandom);
               mode_left     = $urandom_range(16, 96);
            end else begin
               mode_left--;
            end
            pattern_pos = pattern_pos + 3'd1;
            case (ready_mode)
               READY_ALWAYS:  rsp_tready <= 1'b1;
               READY_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
               READY_SPARSE:  rsp_tready <= ($urandom_range(0, 3) == 0);
               READY_PATTERN: rsp_tready <= ready_pattern[pattern_pos];
               default:       rsp_tready <= 1'b1;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result check: every accepted output item is compared, field by field,
   // with the oldest result still owed.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      text_out_type got;
      text_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata, rsp_tuser[0], rsp_tuser[2:1], rsp_tlast};
         if (converted_chars.size() == 0) begin
            $display("%0t: unexpected result: char %h valid %b event %0d last %b",
                     $time, got.ch, got.valid, got.ev, got.last);
            mismatch_count <= mismatch_count + 1;
         end else begin
            want = converted_chars.pop_front();
            if (got !== want) begin
               $display(
                  "%0t: expected %h %b %0d %b, got %h %b %0d %b (char, valid, event, last)",
                  $time, want.ch, want.valid, want.ev, want.last,
                  got.ch, got.valid, got.ev, got.last);
               mismatch_count <= mismatch_count + 1;
            end
            chars_checked <= chars_checked + 1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: no progress, %0d results still owed", $time, converted_chars.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------

   // Writes one register through the APB-style port, reads it back, and
   // updates the model's copy. Only called while the block is idle.
   task automatic set_register(input logic reg_idx, input logic [31:0] value);
      logic [31:0] readback;
      logic [31:0] held;
      held = (reg_idx == REG_IGNORE_ERRORS) ? {31'd0, value[0]} : {24'd0, value[7:0]};
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // The write lands at this edge; a read access follows to read it back.
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== held) begin
         $display("%0t: register %0d read back, expected %h, got %h",
                  $time, reg_idx, held, readback);
         mismatch_count <= mismatch_count + 1;
      end
      if (reg_idx == REG_IGNORE_ERRORS) ign_err = value[0];
      else line_len = value[7:0];
   endtask

   // Waits until every queued byte has been taken and every owed result has
   // come out, then lets the block settle. Polling on the falling edge keeps
   // clear of the handshakes at the rising edge.
   task automatic wait_quiet();
      while (byte_queue.size() != 0 || req_tvalid) @(negedge clock);
      for (int i = 0; i < DRAIN_LIMIT && converted_chars.size() != 0; i++) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_byte(input logic [7:0] data, input logic nf);
      byte_queue.push_back({data, nf, 1'b0, 2'd0, EV_NONE, 24'd0});
      bytes_queued++;
   endtask

   // Queues one block with random content. Most blocks are well formed; some
   // have empty bodies, some are cut short by the next file, and some are
   // plain noise. After anything that leaves the parser misaligned, halted or
   // finished, the next block opens with new_file.
   task automatic queue_random_block(input bit errors_ignored);
      int          pick;
      int          body;
      logic [31:0] blk_len;
      logic [7:0]  kind;
      logic        start_nf;
      bit          has_body;
      pick     = $urandom_range(0, 99);
      start_nf = restart_due || ($urandom_range(0, 5) == 0);
      restart_due = 1'b0;
      if (pick < 10) begin
         repeat ($urandom_range(1, 8)) queue_byte(8'($urandom), $urandom_range(0, 7) == 0);
         restart_due = 1'b1;
         return;
      end
      if (pick < 35)      kind = KIND_TEXT;
      else if (pick < 60) kind = KIND_HEX;
      else if (pick < 72) kind = KIND_SKIP;
      else if (pick < 77) kind = KIND_END;
      else if (pick < 86) kind = ($urandom_range(0, 1) == 1) ? KIND_UNIMPL_A : KIND_UNIMPL_B;
      else                kind = 8'($urandom_range(int'(KIND_END) + 1, 255));
      has_body = (kind == KIND_TEXT || kind == KIND_HEX || kind == KIND_SKIP);

      body    = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      blk_len = body + ((kind == KIND_SKIP) ? 6 : 2);
      case ($urandom_range(0, 9))
         0: begin
            // Zero, small or negative size: the body is empty.
            case ($urandom_range(0, 2))
               0: blk_len = $urandom_range(0, (kind == KIND_SKIP) ? 6 : 2);
               1: blk_len = 32'h8000_0000;
               default: blk_len = {1'b1, 31'($urandom)};
            endcase
            body = 0;
         end
         1: begin
            // Size far beyond the bytes that follow; the next file cuts it.
            blk_len = {1'b0, 31'($urandom)} | 32'h0100_0000;
            if (has_body) restart_due = 1'b1;
         end
         default: ;
      endcase
      if (!has_body) blk_len = $urandom;

      queue_byte(blk_len[31:24], start_nf);
      queue_byte(blk_len[23:16], 1'b0);
      queue_byte(blk_len[15:8], 1'b0);
      queue_byte(blk_len[7:0], 1'b0);
      queue_byte(kind, 1'b0);
      queue_byte(8'($urandom), 1'b0);

      if (has_body) begin
         for (int i = 0; i < body; i++)
            queue_byte((kind == KIND_TEXT && $urandom_range(0, 3) == 0) ? CHAR_CR : 8'($urandom),
                       1'b0);
      end else if (kind == KIND_END || !errors_ignored) begin
         restart_due = 1'b1;
      end
   endtask

   // Directed bytes, run with the registers at their reset values. Rows marked
   // typed carry their results; the hex byte is left to the parser model.
   //   data   nf    typed  count  event        chars (first in low byte)
   font_byte_type directed_bytes [27] = '{
      // Text block, size 3, so one body byte; a carriage return becomes LF.
      '{8'h00, 1'b1, 1'b1, 2'd0, EV_NONE,    24'h0},
      '{8'h00, 1'b0, 1'b1, 2'd0, EV_NONE,    24'h0},
      '{8'h00, 1'b0, 1'b1, 2'd0, EV_NONE,    24'h0},
      '{8'h03, 1'b0, 1'b1, 2'd0, EV_NONE,    24'h0},
      '{KIND_TEXT, 1'b0, 1'b1, 2'd0, EV_NONE, 24'h0},
      '{8'hFF, 1'b0, 1'b1, 2'd0, EV_NONE,    24'h0},
      '{CHAR_CR, 1'b0, 1'b1, 2'd1, EV_NONE,  {16'h0, CHAR_LF}},
      // Hex block with one body byte of all ones.
      '{8'h00, 1'b0, 1'b1, 2'd0, EV_NONE,    24'h0},
      '{8'h00, 1'b0, 1'b1, 2'd0, EV_NONE,    24'h0},
      '{8'h00, 1'b0, 1'b1, 2'd0, EV_NONE,    24'h0},
      '{8'h03, 1'b0, 1'b1, 2'd0, EV_NONE,    24'h0},
      '{KIND_HEX, 1'b0, 1'b1, 2'd0, EV_NONE, 24'h0},
      '{8'hA5, 1'b0, 1'b1, 2'd0, EV_NONE,    24'h0},
      '{8'hFF, 1'b0, 1'b0, 2'd0, EV_NONE,    24'h0},
      // End of font with a size of minus one.
      '{8'hFF, 1'b0, 1'b1, 2'd0, EV_NONE,    24'h0},
      '{8'hFF, 1'b0, 1'b1, 2'd0, EV_NONE,    24'h0},
      '{8'hFF, 1'b0, 1'b1, 2'd0, EV_NONE,    24'h0},
      '{8'hFF, 1'b0, 1'b1, 2'd0, EV_NONE,    24'h0},
      '{KIND_END, 1'b0, 1'b1, 2'd0, EV_NONE, 24'h0},
      '{8'h00, 1'b0, 1'b1, 2'd1, EV_END,     24'h0},
      // A new file restarts the parser after the end; its type is unknown,
      // and with errors not ignored the parser halts and drops the next byte.
      '{8'h80, 1'b1, 1'b1, 2'd0, EV_NONE,    24'h0},
      '{8'h00, 1'b0, 1'b1, 2'd0, EV_NONE,    24'h0},
      '{8'h00, 1'b0, 1'b1, 2'd0, EV_NONE,    24'h0},
      '{8'h00, 1'b0, 1'b1, 2'd0, EV_NONE,    24'h0},
      '{8'hFF, 1'b0, 1'b1, 2'd0, EV_NONE,    24'h0},
      '{8'h7E, 1'b0, 1'b1, 2'd1, EV_UNKNOWN, 24'h0},
      '{8'h41, 1'b0, 1'b1, 2'd0, EV_NONE,    24'h0}
   };

   // Register settings for the random part, one per stretch of blocks. Line
   // lengths cover one byte, 255 bytes, zero (read as 256) and a
   // short line; the last stretch takes a random short length.
   bit         ignore_plan [SETTINGS] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
   logic [7:0] width_plan  [SETTINGS] = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd0};

   initial begin
      int start_count;
      int leftover;
      logic [7:0] width;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, with ignore_errors and line_bytes still at reset.
      @(negedge clock);
      foreach (directed_bytes[i]) byte_queue.push_back(directed_bytes[i]);
      wait_quiet();

      // Random part. Registers change only here, with the block idle.
      for (int s = 0; s < SETTINGS; s++) begin
         width = (s == SETTINGS - 1) ? 8'($urandom_range(2, 12)) : width_plan[s];
         set_register(REG_IGNORE_ERRORS, {31'd0, ignore_plan[s]});
         set_register(REG_LINE_BYTES, {24'd0, width});
         @(negedge clock);
         start_count = bytes_queued;
         while (bytes_queued - start_count < BYTES_PER_SET) queue_random_block(ignore_plan[s]);
         wait_quiet();
      end

      leftover = converted_chars.size();
      if (leftover != 0)
         $display("%0t: %0d results never arrived", $time, leftover);

      $display("Sent %0d font bytes and checked %0d results over %0d register settings.",
               bytes_taken, chars_checked, SETTINGS + 1);
      $display("Blocks of every type, empty and cut-short bodies and a long output stall were run.");
      if (mismatch_count == 0 && leftover == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
